/* src/idm_pkg.sv */
// Shared types, widths and constants of the car-following acceleration block.
// Depends on nothing; every other file in src imports it.
package idm_pkg;

	// Field widths.
	localparam int POS_W     = 24;
	localparam int SPD_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int ACC_W     = 24;

	// Ratio v / v0 in Q16, built by a bit-per-stage divider.
	localparam int RATIO_FRAC = 16;
	localparam int R_Q_W      = 32;

	// Square root of max_accel * comfort_decel.
	localparam int ISQ_N_W = 2 * CFG_W;
	localparam int ROOT_W  = ISQ_N_W / 2;

	// Braking term v * dv / (2 * root).
	localparam int VDV_W     = 2 * SPD_W;
	localparam int BRK_Q_W   = VDV_W;
	localparam int BRK_DEN_W = ROOT_W + 1;
	localparam int VT_W      = 2 * SPD_W - 8;

	// Desired gap over actual gap, Q16; only quotients below 2^28 are exact,
	// larger ones are flagged before they reach the divider and capped after it.
	localparam int GAP_W   = POS_W;
	localparam int NUM_W   = 34;
	localparam int Q_Q_W   = 28;
	localparam int Q_SHIFT = Q_Q_W - RATIO_FRAC;

	// Post-processing: squares, difference, scale, saturation.
	localparam int R2_W        = 2 * R_Q_W - RATIO_FRAC;
	localparam int TERM_W      = 41;
	localparam int D_W         = 42;
	localparam int P_W         = D_W + CFG_W + 1;
	localparam int POST_STAGES = 5;

	localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Register map of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ACCEL     = 3'd0,
		REG_COMFORT_DECEL = 3'd1,
		REG_DESIRED_SPEED = 3'd2,
		REG_JAM_DISTANCE  = 3'd3,
		REG_TIME_HEADWAY  = 3'd4,
		REG_MIN_GAP       = 3'd5
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] RST_MAX_ACCEL     = 16'd256;
	localparam logic [CFG_W-1:0] RST_COMFORT_DECEL = 16'd512;
	localparam logic [CFG_W-1:0] RST_DESIRED_SPEED = 16'd8192;
	localparam logic [CFG_W-1:0] RST_JAM_DISTANCE  = 16'd512;
	localparam logic [CFG_W-1:0] RST_TIME_HEADWAY  = 16'd256;
	localparam logic [CFG_W-1:0] RST_MIN_GAP       = 16'd256;

	typedef struct packed {
		logic [POS_W-1:0] own_position;
		logic [SPD_W-1:0] own_speed;
		logic [SPD_W-1:0] lane_speed_limit;
		logic             leader_present;
		logic [POS_W-1:0] leader_position;
		logic [SPD_W-1:0] leader_speed;
		logic [SPD_W-1:0] leader_length;
		logic             light_red;
		logic [POS_W-1:0] light_position;
	} idm_req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acceleration;
		logic                    saturated;
	} idm_rsp_t;

	// Side data that travels alongside each divider or root pipeline.
	typedef struct packed {
		logic             lead;
		logic [VDV_W-1:0] vdv_mag;
		logic             vdv_neg;
		logic [GAP_W-1:0] gap;
		logic [VT_W-1:0]  vt;
		logic [ISQ_N_W-1:0] ab;
	} seg_a_t;

	typedef struct packed {
		logic             lead;
		logic [VDV_W-1:0] vdv_mag;
		logic             vdv_neg;
		logic [GAP_W-1:0] gap;
		logic [VT_W-1:0]  vt;
		logic [R_Q_W-1:0] ratio;
	} seg_b_t;

	typedef struct packed {
		logic             lead;
		logic             vdv_neg;
		logic [GAP_W-1:0] gap;
		logic [VT_W-1:0]  vt;
		logic [R_Q_W-1:0] ratio;
	} seg_c_t;

	typedef struct packed {
		logic             lead;
		logic             ovf;
		logic [R_Q_W-1:0] ratio;
	} seg_d_t;

endpackage

/* src/idm_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on idm_pkg for default widths.
module idm_div #(
	parameter int Q_W    = idm_pkg::R_Q_W,
	parameter int DEN_W  = idm_pkg::SPD_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [Q_W-1:0]    in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    out_quo,
	output logic [SIDE_W-1:0] out_side
);
	import idm_pkg::*;

	// The starting remainder must be below the divisor for an exact result.
	logic              valid_s [0:Q_W-1];
	logic [DEN_W-1:0]  rem_s   [0:Q_W-1];
	logic [Q_W-1:0]    num_s   [0:Q_W-1];
	logic [DEN_W-1:0]  den_s   [0:Q_W-1];
	logic [SIDE_W-1:0] side_s  [0:Q_W-1];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic              cur_valid;
		logic [DEN_W-1:0]  cur_rem;
		logic [Q_W-1:0]    cur_num;
		logic [DEN_W-1:0]  cur_den;
		logic [SIDE_W-1:0] cur_side;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;

		if (k == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_rem   = in_rem;
			assign cur_num   = in_num;
			assign cur_den   = in_den;
			assign cur_side  = in_side;
		end else begin : g_next
			assign cur_valid = valid_s[k-1];
			assign cur_rem   = rem_s[k-1];
			assign cur_num   = num_s[k-1];
			assign cur_den   = den_s[k-1];
			assign cur_side  = side_s[k-1];
		end

		assign trial = {cur_rem, cur_num[Q_W-1]};
		assign diff  = trial - {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (cur_valid) begin
				if (trial >= {1'b0, cur_den}) begin
					rem_s[k] <= diff[DEN_W-1:0];
					num_s[k] <= {cur_num[Q_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial[DEN_W-1:0];
					num_s[k] <= {cur_num[Q_W-2:0], 1'b0};
				end
				den_s[k]  <= cur_den;
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = valid_s[Q_W-1];
	assign out_quo   = num_s[Q_W-1];
	assign out_side  = side_s[Q_W-1];

endmodule

/* src/idm_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on idm_pkg for default widths.
module idm_isqrt #(
	parameter int N_W    = idm_pkg::ISQ_N_W,
	parameter int SIDE_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [N_W-1:0]     in_n,
	input  logic [SIDE_W-1:0]  in_side,
	output logic               out_valid,
	output logic [N_W/2-1:0]   out_root,
	output logic [SIDE_W-1:0]  out_side
);
	import idm_pkg::*;

	localparam int STEPS = N_W / 2;

	logic              valid_s [0:STEPS-1];
	logic [N_W-1:0]    n_s     [0:STEPS-1];
	logic [N_W-1:0]    res_s   [0:STEPS-1];
	logic [SIDE_W-1:0] side_s  [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [N_W:0] BIT = (N_W+1)'(1) << (N_W - 2 - 2 * k);
		logic              cur_valid;
		logic [N_W-1:0]    cur_n;
		logic [N_W-1:0]    cur_res;
		logic [SIDE_W-1:0] cur_side;
		logic [N_W:0]      sum;
		logic              take;

		if (k == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_n     = in_n;
			assign cur_res   = '0;
			assign cur_side  = in_side;
		end else begin : g_next
			assign cur_valid = valid_s[k-1];
			assign cur_n     = n_s[k-1];
			assign cur_res   = res_s[k-1];
			assign cur_side  = side_s[k-1];
		end

		assign sum  = {1'b0, cur_res} + BIT;
		assign take = {1'b0, cur_n} >= sum;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (cur_valid) begin
				if (take) begin
					n_s[k]   <= cur_n - sum[N_W-1:0];
					res_s[k] <= (cur_res >> 1) + BIT[N_W-1:0];
				end else begin
					n_s[k]   <= cur_n;
					res_s[k] <= cur_res >> 1;
				end
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = valid_s[STEPS-1];
	assign out_root  = res_s[STEPS-1][STEPS-1:0];
	assign out_side  = side_s[STEPS-1];

endmodule

/* src/idm_post.sv */
// Final stages: free-road and interaction squares, difference, scaling by
// max_accel and saturation. Depends on idm_pkg.
module idm_post (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [idm_pkg::R_Q_W-1:0]    in_ratio,
	input  logic [idm_pkg::Q_Q_W-1:0]    in_qmag,
	input  logic                         in_ovf,
	input  logic                         in_lead,
	input  logic [idm_pkg::CFG_W-1:0]    max_accel,
	output logic                         out_valid,
	output idm_pkg::idm_rsp_t            out_result
);
	import idm_pkg::*;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [R2_W-1:0]          r2_s1;
	logic [TERM_W-1:0]        w_s1, w_s2, r4_s2;
	logic signed [D_W-1:0]    d_s3;
	logic signed [P_W-1:0]    p_s4;
	idm_rsp_t                 rsp_s5;

	logic [2*R_Q_W-1:0]       r_sq_c;
	logic [2*Q_Q_W-1:0]       q_sq_c;
	logic [2*Q_Q_W-1:0]       r2_sq_c;
	logic signed [D_W:0]      d_c;
	logic signed [P_W-1:0]    p_c;
	logic                     neg_c;
	logic [P_W-1:0]           abs_c;
	logic [P_W-RATIO_FRAC-1:0] mag_c;
	idm_rsp_t                 rsp_c;

	always_comb begin
		r_sq_c  = in_ratio * in_ratio;
		q_sq_c  = in_qmag * in_qmag;
		r2_sq_c = r2_s1[Q_Q_W-1:0] * r2_s1[Q_Q_W-1:0];
		d_c = $signed((D_W+1)'(1 << RATIO_FRAC)) - $signed({2'b0, r4_s2})
			- $signed({2'b0, w_s2});
		p_c = d_s3 * $signed({1'b0, max_accel});
	end

	always_comb begin
		neg_c = p_s4[P_W-1];
		abs_c = neg_c ? P_W'(-p_s4) : p_s4;
		mag_c = abs_c[P_W-1:RATIO_FRAC];
		rsp_c.saturated    = 1'b0;
		rsp_c.acceleration = ACC_W'(mag_c);
		if (!neg_c) begin
			if (mag_c > (P_W-RATIO_FRAC)'(ACC_MAX)) begin
				rsp_c.saturated    = 1'b1;
				rsp_c.acceleration = ACC_MAX;
			end
		end else begin
			if (mag_c > (P_W-RATIO_FRAC)'(1 << (ACC_W - 1))) begin
				rsp_c.saturated    = 1'b1;
				rsp_c.acceleration = ACC_MIN;
			end else begin
				rsp_c.acceleration = ACC_W'(-mag_c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			r2_s1 <= r_sq_c[2*R_Q_W-1:RATIO_FRAC];
			if (!in_lead) begin
				w_s1 <= '0;
			end else if (in_ovf) begin
				w_s1 <= TERM_CAP;
			end else begin
				w_s1 <= TERM_W'(q_sq_c >> RATIO_FRAC);
			end
		end
		if (valid_s1) begin
			w_s2 <= w_s1;
			if (|r2_s1[R2_W-1:Q_Q_W]) begin
				r4_s2 <= TERM_CAP;
			end else begin
				r4_s2 <= TERM_W'(r2_sq_c >> RATIO_FRAC);
			end
		end
		if (valid_s2) begin
			if (d_c < -$signed({2'b0, TERM_CAP})) begin
				d_s3 <= -$signed({1'b0, TERM_CAP});
			end else begin
				d_s3 <= d_c[D_W-1:0];
			end
		end
		if (valid_s3) begin
			p_s4 <= p_c;
		end
		if (valid_s4) begin
			rsp_s5 <= rsp_c;
		end
	end

	assign out_valid  = valid_s5;
	assign out_result = rsp_s5;

endmodule

/* src/idm_car_following_acceleration.sv */
// Top level of the car-following acceleration block: configuration registers,
// input stages and the chain of divider and root pipelines. Depends on idm_pkg,
// idm_div, idm_isqrt and idm_post.
//
// This block evaluates the Intelligent Driver Model acceleration of one vehicle
// per request and accepts a new request on every clock cycle; busy stays low.
// Each request produces exactly one result, shown on result for a single cycle
// with result_valid high. Results come out in request order and cannot be
// held off, so the receiver must take every result as it appears. A request
// passes through two input stages, the 32-stage ratio divider, the 16-stage
// square root, the 32-stage braking divider, two stages that form the desired
// gap, the 28-stage gap divider and five stages of squaring, scaling and
// saturation. Configuration writes are always accepted (cfg_ready is high)
// and must only be issued while no request is in flight; indexes beyond the
// register map are ignored.
module idm_car_following_acceleration (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  idm_pkg::idm_req_t             request,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [idm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [idm_pkg::CFG_W-1:0]     cfg_data,
	output logic                          result_valid,
	output idm_pkg::idm_rsp_t             result
);
	import idm_pkg::*;

	localparam int LATENCY = 2 + R_Q_W + ROOT_W + BRK_Q_W + 2 + Q_Q_W + POST_STAGES;

	// Configuration registers.
	logic [CFG_W-1:0] max_accel_q, comfort_decel_q, desired_speed_q;
	logic [CFG_W-1:0] jam_distance_q, time_headway_q, min_gap_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_accel_q     <= RST_MAX_ACCEL;
			comfort_decel_q <= RST_COMFORT_DECEL;
			desired_speed_q <= RST_DESIRED_SPEED;
			jam_distance_q  <= RST_JAM_DISTANCE;
			time_headway_q  <= RST_TIME_HEADWAY;
			min_gap_q       <= RST_MIN_GAP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_ACCEL:     max_accel_q     <= cfg_data;
				REG_COMFORT_DECEL: comfort_decel_q <= cfg_data;
				REG_DESIRED_SPEED: desired_speed_q <= cfg_data;
				REG_JAM_DISTANCE:  jam_distance_q  <= cfg_data;
				REG_TIME_HEADWAY:  time_headway_q  <= cfg_data;
				REG_MIN_GAP:       min_gap_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: pick the effective leader, form the gap, the speed bound, v * T and
	// the configuration-only product. A red light ahead replaces a missing
	// leader or one that sits at or beyond the stop line.
	logic                    accept;
	logic                    light_hit_c, lead_c;
	logic [POS_W-1:0]        lpos_c;
	logic [SPD_W-1:0]        lspd_c, llen_c, v0_c;
	logic signed [POS_W+1:0] gap_raw_c;
	logic [CFG_W-1:0]        gmin_c;
	logic [GAP_W-1:0]        gap_c;
	logic [2*SPD_W-1:0]      vt_prod_c;
	logic signed [SPD_W:0]   dv_c;

	assign accept = start && !busy;

	always_comb begin
		light_hit_c = request.light_red
			&& (!request.leader_present
				|| request.leader_position >= request.light_position)
			&& (request.own_position < request.light_position);
		lead_c = request.leader_present || light_hit_c;
		lpos_c = light_hit_c ? request.light_position : request.leader_position;
		lspd_c = light_hit_c ? '0 : request.leader_speed;
		llen_c = light_hit_c ? '0 : request.leader_length;
		v0_c = (request.lane_speed_limit < desired_speed_q) ? request.lane_speed_limit
			: desired_speed_q;
		if (v0_c == '0) begin
			v0_c = SPD_W'(1);
		end
		gap_raw_c = $signed({2'b0, lpos_c}) - $signed({2'b0, request.own_position})
			- $signed((POS_W+2)'(llen_c));
		gmin_c = (min_gap_q == '0) ? CFG_W'(1) : min_gap_q;
		gap_c = (gap_raw_c < $signed((POS_W+2)'(gmin_c))) ? GAP_W'(gmin_c)
			: gap_raw_c[GAP_W-1:0];
		vt_prod_c = request.own_speed * time_headway_q;
		dv_c = $signed({1'b0, request.own_speed}) - $signed({1'b0, lspd_c});
	end

	logic                  valid_s1;
	logic [SPD_W-1:0]      v_s1, v0_s1;
	logic                  lead_s1;
	logic signed [SPD_W:0] dv_s1;
	logic [GAP_W-1:0]      gap_s1;
	logic [VT_W-1:0]       vt_s1;
	logic [ISQ_N_W-1:0]    ab_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1    <= request.own_speed;
			v0_s1   <= v0_c;
			lead_s1 <= lead_c;
			dv_s1   <= dv_c;
			gap_s1  <= gap_c;
			vt_s1   <= vt_prod_c[2*SPD_W-1:8];
			ab_s1   <= max_accel_q * comfort_decel_q;
		end
	end

	// Stage 2: magnitude and sign of v * dv for the braking term.
	logic [SPD_W:0]  dv_abs_c;
	logic            valid_s2;
	logic [SPD_W-1:0] v_s2, v0_s2;
	seg_a_t          seg_a_s2;

	assign dv_abs_c = dv_s1[SPD_W] ? (SPD_W+1)'(-dv_s1) : dv_s1;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			v_s2             <= v_s1;
			v0_s2            <= v0_s1;
			seg_a_s2.lead    <= lead_s1;
			seg_a_s2.vdv_mag <= v_s1 * dv_abs_c[SPD_W-1:0];
			seg_a_s2.vdv_neg <= dv_s1[SPD_W];
			seg_a_s2.gap     <= gap_s1;
			seg_a_s2.vt      <= vt_s1;
			seg_a_s2.ab      <= ab_s1;
		end
	end

	// Ratio v / v0 in Q16.
	logic             ratio_valid;
	logic [R_Q_W-1:0] ratio_quo;
	seg_a_t           seg_a_out;

	idm_div #(
		.Q_W    (R_Q_W),
		.DEN_W  (SPD_W),
		.SIDE_W ($bits(seg_a_t))
	) u_ratio_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_rem    ('0),
		.in_num    ({v_s2, {RATIO_FRAC{1'b0}}}),
		.in_den    (v0_s2),
		.in_side   (seg_a_s2),
		.out_valid (ratio_valid),
		.out_quo   (ratio_quo),
		.out_side  (seg_a_out)
	);

	// Root of max_accel * comfort_decel.
	seg_b_t            seg_b_in, seg_b_out;
	logic              root_valid;
	logic [ROOT_W-1:0] root;

	always_comb begin
		seg_b_in.lead    = seg_a_out.lead;
		seg_b_in.vdv_mag = seg_a_out.vdv_mag;
		seg_b_in.vdv_neg = seg_a_out.vdv_neg;
		seg_b_in.gap     = seg_a_out.gap;
		seg_b_in.vt      = seg_a_out.vt;
		seg_b_in.ratio   = ratio_quo;
	end

	idm_isqrt #(
		.N_W    (ISQ_N_W),
		.SIDE_W ($bits(seg_b_t))
	) u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ratio_valid),
		.in_n      (seg_a_out.ab),
		.in_side   (seg_b_in),
		.out_valid (root_valid),
		.out_root  (root),
		.out_side  (seg_b_out)
	);

	// Braking term magnitude |v * dv| / (2 * root); a zero root divides by one.
	seg_c_t               seg_c_in, seg_c_out;
	logic [BRK_DEN_W-1:0] brk_den_c;
	logic                 brk_valid;
	logic [BRK_Q_W-1:0]   brk_quo;

	always_comb begin
		brk_den_c = (root == '0) ? BRK_DEN_W'(1) : {root, 1'b0};
		seg_c_in.lead    = seg_b_out.lead;
		seg_c_in.vdv_neg = seg_b_out.vdv_neg;
		seg_c_in.gap     = seg_b_out.gap;
		seg_c_in.vt      = seg_b_out.vt;
		seg_c_in.ratio   = seg_b_out.ratio;
	end

	idm_div #(
		.Q_W    (BRK_Q_W),
		.DEN_W  (BRK_DEN_W),
		.SIDE_W ($bits(seg_c_t))
	) u_brake_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_valid),
		.in_rem    ('0),
		.in_num    (seg_b_out.vdv_mag),
		.in_den    (brk_den_c),
		.in_side   (seg_c_in),
		.out_valid (brk_valid),
		.out_quo   (brk_quo),
		.out_side  (seg_c_out)
	);

	// Stage 3: desired gap s* = s0 + v*T + signed braking term.
	logic signed [NUM_W-1:0] brake_c, num_c;
	logic                    valid_s3, lead_s3;
	logic signed [NUM_W-1:0] num_s3;
	logic [GAP_W-1:0]        gap_s3;
	logic [R_Q_W-1:0]        ratio_s3;

	always_comb begin
		brake_c = seg_c_out.vdv_neg ? -$signed(NUM_W'(brk_quo)) : $signed(NUM_W'(brk_quo));
		num_c = $signed(NUM_W'(jam_distance_q)) + $signed(NUM_W'(seg_c_out.vt)) + brake_c;
	end

	always_ff @(posedge clk) begin
		if (brk_valid) begin
			num_s3   <= num_c;
			lead_s3  <= seg_c_out.lead;
			gap_s3   <= seg_c_out.gap;
			ratio_s3 <= seg_c_out.ratio;
		end
	end

	// Stage 4: magnitude of s* and the early cap test. A quotient of 2^28 or
	// more squares past the cap, so it only has to be flagged, not divided.
	logic [NUM_W-1:0]  num_abs_c;
	logic              ovf_c;
	logic              valid_s4;
	logic [GAP_W-1:0]  rem_s4, gap_s4;
	logic [Q_Q_W-1:0]  nlow_s4;
	seg_d_t            seg_d_s4;

	always_comb begin
		num_abs_c = num_s3[NUM_W-1] ? NUM_W'(-num_s3) : num_s3;
		ovf_c = (GAP_W+Q_SHIFT)'(num_abs_c) >= {gap_s3, {Q_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			rem_s4         <= ovf_c ? '0 : GAP_W'(num_abs_c >> Q_SHIFT);
			nlow_s4        <= {num_abs_c[Q_SHIFT-1:0], {RATIO_FRAC{1'b0}}};
			gap_s4         <= gap_s3;
			seg_d_s4.lead  <= lead_s3;
			seg_d_s4.ovf   <= ovf_c;
			seg_d_s4.ratio <= ratio_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= brk_valid;
			valid_s4 <= valid_s3;
		end
	end

	// Interaction ratio s* / s in Q16.
	logic             q_valid;
	logic [Q_Q_W-1:0] q_quo;
	seg_d_t           seg_d_out;

	idm_div #(
		.Q_W    (Q_Q_W),
		.DEN_W  (GAP_W),
		.SIDE_W ($bits(seg_d_t))
	) u_gap_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_rem    (rem_s4),
		.in_num    (nlow_s4),
		.in_den    (gap_s4),
		.in_side   (seg_d_s4),
		.out_valid (q_valid),
		.out_quo   (q_quo),
		.out_side  (seg_d_out)
	);

	idm_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ratio   (seg_d_out.ratio),
		.in_qmag    (q_quo),
		.in_ovf     (seg_d_out.ovf),
		.in_lead    (seg_d_out.lead),
		.max_accel  (max_accel_q),
		.out_valid  (result_valid),
		.out_result (result)
	);

	// Every accepted request leaves the pipeline as a result, and no result comes without one.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY result_valid)
		else $error("request did not produce a result on time");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept, LATENCY))
		else $error("result without a matching request");

	// The result never exceeds max_accel, so only the negative end can clamp.
	a_sat_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturated) |-> (result.acceleration == ACC_MIN))
		else $error("saturation on the positive side");

endmodule

/* tb/tb_idm_car_following_acceleration.sv */
// Self-checking testbench of the car-following acceleration block.
// It needs the package idm_pkg and the block idm_car_following_acceleration.
// It holds its own fixed-point model of the block and checks every result against it or against a hand-written answer.
module tb_idm_car_following_acceleration;
	timeunit 1ns;
	timeprecision 1ps;

	import idm_pkg::*;

	// Watchdog: this many cycles without any handshake or result ends the run.
	localparam int STALL_LIMIT = 5000;
	// Drain time after the last result, a bit above the pipeline latency.
	localparam int DRAIN_CYCLES = 130;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 235;
	// Indexes past the register map, which the block must ignore.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint ONE_Q16 = 64'sd65536;
	localparam longint BIG_TERM = 64'sd1 << 40;

	typedef struct {
		idm_req_t req;
		bit       known;
		idm_rsp_t want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	idm_req_t             request;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 result_valid;
	idm_rsp_t             result;

	// Whether the request being driven carries a hand-written answer.
	bit       row_known;
	idm_rsp_t row_want;

	// The testbench's own copy of the configuration registers.
	longint m_accel, m_decel, m_vdes, m_jam, m_headway, m_mingap;

	idm_rsp_t accel_due[$];
	int       n_requests;
	int       n_results;
	int       n_cfg_writes;
	int       n_errors;
	int       idle_cycles;
	int       n_saturated;
	int       n_led;

	idm_car_following_acceleration dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Integer square root, bit by bit, of a product of two 16-bit registers.
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Squares a Q16 magnitude; anything at or above 2^40 is held at 2^40.
	function automatic longint square_q16(input longint unsigned m);
		longint unsigned sq;
		if (m >= (64'd1 << 28))
			return BIG_TERM;
		sq = (m * m) >> 16;
		if (sq > BIG_TERM)
			return BIG_TERM;
		return longint'(sq);
	endfunction

	// Expected acceleration of one vehicle under the current register copy.
	function automatic idm_rsp_t idm_accel(input idm_req_t it);
		longint unsigned ratio, ratio2;
		longint v, v0, r4, w, d, p, acc;
		longint lpos, lspd, llen, dv, vt, den, num, gap, gmin, q;
		bit lead;
		bit sat;
		idm_rsp_t rsp;
		v = it.own_speed;
		v0 = (it.lane_speed_limit < m_vdes) ? it.lane_speed_limit : m_vdes;
		if (v0 == 0)
			v0 = 1;
		ratio = (unsigned'(v) << 16) / unsigned'(v0);
		ratio2 = (ratio * ratio) >> 16;
		r4 = square_q16(ratio2);
		lead = it.leader_present;
		lpos = it.leader_position;
		lspd = it.leader_speed;
		llen = it.leader_length;
		// A red light ahead acts as a stopped leader of zero length, unless
		// the real leader is already closer than the stop line.
		if (it.light_red && (!lead || lpos >= it.light_position)
				&& it.own_position < it.light_position) begin
			lead = 1'b1;
			lpos = it.light_position;
			lspd = 0;
			llen = 0;
		end
		w = 0;
		if (lead) begin
			dv = v - lspd;
			vt = (v * m_headway) >>> 8;
			den = 2 * longint'(int_sqrt(unsigned'(m_accel * m_decel)));
			if (den == 0)
				den = 1;
			num = m_jam + vt + (v * dv) / den;
			gap = lpos - longint'(it.own_position) - llen;
			gmin = (m_mingap != 0) ? m_mingap : 1;
			if (gap < gmin)
				gap = gmin;
			q = (num * ONE_Q16) / gap;
			w = square_q16(unsigned'(q < 0 ? -q : q));
		end
		d = ONE_Q16 - r4 - w;
		if (d < -BIG_TERM)
			d = -BIG_TERM;
		p = m_accel * d;
		acc = (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
		sat = 1'b0;
		if (acc > 64'sd8388607) begin
			acc = 64'sd8388607;
			sat = 1'b1;
		end else if (acc < -64'sd8388608) begin
			acc = -64'sd8388608;
			sat = 1'b1;
		end
		rsp.acceleration = acc[ACC_W-1:0];
		rsp.saturated = sat;
		return rsp;
	endfunction

	function automatic idm_req_t vehicle(input longint pos, input longint spd,
			input longint lim, input bit lp, input longint lpos, input longint lspd,
			input longint llen, input bit red, input longint light);
		idm_req_t it;
		it.own_position = pos[POS_W-1:0];
		it.own_speed = spd[SPD_W-1:0];
		it.lane_speed_limit = lim[SPD_W-1:0];
		it.leader_present = lp;
		it.leader_position = lpos[POS_W-1:0];
		it.leader_speed = lspd[SPD_W-1:0];
		it.leader_length = llen[SPD_W-1:0];
		it.light_red = red;
		it.light_position = light[POS_W-1:0];
		return it;
	endfunction

	// Random vehicle: mostly a plausible traffic scene around the current
	// settings, sometimes pure noise so that every bit of every field toggles.
	function automatic idm_req_t random_vehicle();
		idm_req_t it;
		longint pos, spd;
		if ($urandom_range(0, 9) < 2) begin
			it = ($bits(idm_req_t))'({$urandom, $urandom, $urandom, $urandom, $urandom});
			return it;
		end
		pos = $urandom_range(0, 24'hFFFFFF);
		spd = $urandom_range(0, (m_vdes + m_vdes / 4 > 65535) ? 65535
			: m_vdes + m_vdes / 4);
		return vehicle(pos, spd,
			($urandom_range(0, 2) == 0) ? $urandom_range(1, 65535) : m_vdes,
			$urandom_range(0, 3) != 0,
			pos + $urandom_range(0, 40000),
			($urandom_range(0, 1) == 0) ? spd + $urandom_range(0, 512) - 256
				: $urandom_range(0, 65535),
			$urandom_range(0, 1500),
			$urandom_range(0, 1),
			pos + $urandom_range(0, 60000) - 3000);
	endfunction

	function automatic logic [CFG_W-1:0] random_setting(input bit zero_ok);
		case ($urandom_range(0, 4))
			0: return zero_ok ? 16'd0 : 16'd1;
			1: return 16'hFFFF;
			2: return CFG_W'($urandom_range(1, 65535));
			default: return CFG_W'($urandom_range(64, 2048));
		endcase
	endfunction

	// Requests, results and register writes are all sampled at the rising edge.
	always @(posedge clk) begin : monitor
		bit       progress;
		int       errs;
		idm_rsp_t want;
		progress = 1'b0;
		errs = 0;
		if (arst_n) begin
			if (start && !busy) begin
				accel_due.insert(accel_due.size(),
					row_known ? row_want : idm_accel(request));
				n_requests <= n_requests + 1;
				if (request.leader_present)
					n_led <= n_led + 1;
				progress = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_ACCEL:     m_accel = cfg_data;
					REG_COMFORT_DECEL: m_decel = cfg_data;
					REG_DESIRED_SPEED: m_vdes = cfg_data;
					REG_JAM_DISTANCE:  m_jam = cfg_data;
					REG_TIME_HEADWAY:  m_headway = cfg_data;
					REG_MIN_GAP:       m_mingap = cfg_data;
					default: ;
				endcase
				n_cfg_writes <= n_cfg_writes + 1;
				progress = 1'b1;
			end
			if (result_valid) begin
				progress = 1'b1;
				n_results <= n_results + 1;
				if (result.saturated)
					n_saturated <= n_saturated + 1;
				if (accel_due.size() == 0) begin
					$error("unexpected result: acceleration %0d", result.acceleration);
					errs = errs + 1;
				end else begin
					want = accel_due[0];
					accel_due.delete(0);
					if (result.acceleration !== want.acceleration) begin
						$error("acceleration: expected %0d, got %0d",
							want.acceleration, result.acceleration);
						errs = errs + 1;
					end
					if (result.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b",
							want.saturated, result.saturated);
						errs = errs + 1;
					end
				end
			end
			idle_cycles <= progress ? 0 : idle_cycles + 1;
			n_errors <= n_errors + errs;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Every task below starts and ends at a falling edge. A request stays
	// raised into the next one when there is no gap, so start is never
	// lowered and raised again within one step.
	task automatic send_vehicle(input idm_req_t it, input bit known,
			input idm_rsp_t want, input int gap);
		int seen;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		request <= it;
		row_known <= known;
		row_want <= want;
		seen = n_requests;
		do @(negedge clk); while (n_requests == seen);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		int seen;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		seen = n_cfg_writes;
		do @(negedge clk); while (n_cfg_writes == seen);
	endtask

	// Stop issuing and let every outstanding request come back.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (accel_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
			input logic [CFG_W-1:0] vd, input logic [CFG_W-1:0] jam,
			input logic [CFG_W-1:0] th, input logic [CFG_W-1:0] mg);
		write_reg(REG_MAX_ACCEL, a);
		write_reg(REG_COMFORT_DECEL, b);
		write_reg(REG_DESIRED_SPEED, vd);
		write_reg(REG_JAM_DISTANCE, jam);
		write_reg(REG_TIME_HEADWAY, th);
		write_reg(REG_MIN_GAP, mg);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly back-to-back, sometimes a short pause, rarely a long one.
	function automatic int random_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		idm_rsp_t none;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		row_known = 1'b0;
		row_want = '0;
		none = '0;
		m_accel = RST_MAX_ACCEL;
		m_decel = RST_COMFORT_DECEL;
		m_vdes = RST_DESIRED_SPEED;
		m_jam = RST_JAM_DISTANCE;
		m_headway = RST_TIME_HEADWAY;
		m_mingap = RST_MIN_GAP;
		n_requests = 0;
		n_results = 0;
		n_cfg_writes = 0;
		n_errors = 0;
		idle_cycles = 0;
		n_saturated = 0;
		n_led = 0;

		// Directed scenes under the reset settings. The first three answers
		// follow by hand: a standing car on an empty road gets max_accel, a car
		// at exactly its target speed gets zero, and a car far over a tiny
		// limit drives the free-road term to its cap and saturates negative.
		row.known = 1'b1;
		row.req = vehicle(1000, 0, 8192, 0, 0, 0, 0, 0, 0);
		row.want = '{acceleration: 24'sd256, saturated: 1'b0};
		rows.insert(rows.size(), row);
		row.req = vehicle(1000, 8192, 8192, 0, 0, 0, 0, 0, 0);
		row.want = '{acceleration: 24'sd0, saturated: 1'b0};
		rows.insert(rows.size(), row);
		row.req = vehicle(1000, 65535, 1, 0, 0, 0, 0, 0, 0);
		row.want = '{acceleration: ACC_MIN, saturated: 1'b1};
		rows.insert(rows.size(), row);
		row.known = 1'b0;
		row.want = none;
		// Zero lane limit, leader inside min_gap, leader behind us.
		row.req = vehicle(1000, 100, 0, 0, 0, 0, 0, 0, 0);
		rows.insert(rows.size(), row);
		row.req = vehicle(5000, 2000, 8192, 1, 5010, 1000, 0, 0, 0);
		rows.insert(rows.size(), row);
		row.req = vehicle(5000, 2000, 8192, 1, 4000, 1000, 300, 0, 0);
		rows.insert(rows.size(), row);
		// Red light alone, light in front of the leader, leader in front of
		// the light, leader exactly on the stop line.
		row.req = vehicle(5000, 3000, 8192, 0, 0, 0, 0, 1, 9000);
		rows.insert(rows.size(), row);
		row.req = vehicle(5000, 3000, 8192, 1, 20000, 3000, 500, 1, 9000);
		rows.insert(rows.size(), row);
		row.req = vehicle(5000, 3000, 8192, 1, 7000, 3000, 500, 1, 9000);
		rows.insert(rows.size(), row);
		row.req = vehicle(5000, 3000, 8192, 1, 9000, 3000, 500, 1, 9000);
		rows.insert(rows.size(), row);
		// Light behind us and light right at our position are both ignored.
		row.req = vehicle(5000, 3000, 8192, 0, 0, 0, 0, 1, 4000);
		rows.insert(rows.size(), row);
		row.req = vehicle(5000, 3000, 8192, 0, 0, 0, 0, 1, 5000);
		rows.insert(rows.size(), row);
		// Faster leader (negative closing speed), far fast leader, all ones,
		// all zeros.
		row.req = vehicle(5000, 2000, 8192, 1, 8000, 6000, 400, 0, 0);
		rows.insert(rows.size(), row);
		row.req = vehicle(0, 4000, 65535, 1, 24'hFFFFFF, 65535, 0, 0, 0);
		rows.insert(rows.size(), row);
		row.req = '1;
		rows.insert(rows.size(), row);
		row.req = '0;
		rows.insert(rows.size(), row);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_vehicle(rows[i].req, rows[i].known, rows[i].want, (i % 4 == 3) ? 2 : 0);
		drain();

		// Extreme settings: everything at the top, then a zero root with a zero
		// gap clamp, then the spare register indexes, which must change nothing.
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		foreach (rows[i])
			send_vehicle(rows[i].req, 1'b0, none, 0);
		drain();
		program_regs(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0000);
		cfg_valid <= 1'b0;
		@(negedge clk);
		foreach (rows[i])
			send_vehicle(rows[i].req, 1'b0, none, random_gap());
		drain();

		// Random phases, the first under the reset settings, each later one under fresh random settings.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0)
				program_regs(RST_MAX_ACCEL, RST_COMFORT_DECEL, RST_DESIRED_SPEED,
					RST_JAM_DISTANCE, RST_TIME_HEADWAY, RST_MIN_GAP);
			else
				program_regs(random_setting(1'b0), random_setting(1'b0),
					random_setting(1'b0), random_setting(1'b1),
					random_setting(1'b1), random_setting(1'b0));
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_vehicle(random_vehicle(), 1'b0, none, random_gap());
			drain();
		end

		$display("covered %0d vehicles (%0d with a leader), %0d results, %0d saturated,",
			n_requests, n_led, n_results, n_saturated);
		$display("  %0d register writes across %0d settings", n_cfg_writes,
			RANDOM_PHASES + 3);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
src/idm_pkg.sv
src/idm_div.sv
src/idm_isqrt.sv
src/idm_post.sv
src/idm_car_following_acceleration.sv
tb/tb_idm_car_following_acceleration.sv
